@@ design/vector3_normalize_core_assert.svh @@
// Assertion macros for the vector normalise core checker
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH

// same-cycle implication, reset-qualified
`define V3N_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset-qualified
`define V3N_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/v3n_pkg.sv @@
// Types and constants for the vector normalise core
package v3n_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned RemW   = 33;
  localparam int unsigned QW     = 31;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned Q30Sh  = 30;

  typedef struct packed {
    logic signed [CompW-1:0] vec_x;
    logic signed [CompW-1:0] vec_y;
    logic signed [CompW-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [CompW-1:0] unit_x;
    logic signed [CompW-1:0] unit_y;
    logic signed [CompW-1:0] unit_z;
    logic        [CompW-1:0] vec_length;
    logic                    zero_length;
  } out_t;

  typedef struct packed {
    logic                         valid;
    logic [SqW-1:0]               rad;
    logic [RemW-1:0]              rem;
    logic [RootW-1:0]             root;
    logic [Lanes-1:0][CompW-1:0]  mag;
    logic [Lanes-1:0]             neg;
  } sq_t;

  typedef struct packed {
    logic                         valid;
    logic [RootW-1:0]             len;
    logic [Lanes-1:0][RootW-1:0]  rem;
    logic [Lanes-1:0][QW-1:0]     nb;
    logic [Lanes-1:0][QW-1:0]     quo;
    logic [Lanes-1:0]             neg;
  } dv_t;

endpackage

@@ design/v3n_sqrt_cell.sv @@
// One root digit of the square root chain
module v3n_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  v3n_pkg::sq_t    d_in,
  output v3n_pkg::sq_t    d_out
);

  v3n_pkg::sq_t q_r, q_nxt;
  logic [v3n_pkg::RemW+1:0] rem_sh, trial, diff;
  logic ge;

  always_comb begin
    rem_sh = {d_in.rem, d_in.rad[v3n_pkg::SqW-1 -: 2]};
    trial  = {1'b0, d_in.root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
    q_nxt      = d_in;
    q_nxt.rad  = {d_in.rad[v3n_pkg::SqW-3:0], 2'b00};
    q_nxt.rem  = ge ? diff[v3n_pkg::RemW-1:0] : rem_sh[v3n_pkg::RemW-1:0];
    q_nxt.root = {d_in.root[v3n_pkg::RootW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

@@ design/v3n_div_cell.sv @@
// One quotient bit of the division chain, three lanes
module v3n_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  v3n_pkg::dv_t    d_in,
  output v3n_pkg::dv_t    d_out
);

  v3n_pkg::dv_t q_r, q_nxt;
  logic [v3n_pkg::RootW:0] r2 [v3n_pkg::Lanes];
  logic [v3n_pkg::RootW:0] diff [v3n_pkg::Lanes];
  logic [v3n_pkg::Lanes-1:0] ge;

  always_comb begin
    q_nxt = d_in;
    for (int i = 0; i < v3n_pkg::Lanes; i++) begin
      r2[i]   = {d_in.rem[i], d_in.nb[i][v3n_pkg::QW-1]};
      ge[i]   = r2[i] >= {1'b0, d_in.len};
      diff[i] = r2[i] - {1'b0, d_in.len};
      q_nxt.rem[i] = ge[i] ? diff[i][v3n_pkg::RootW-1:0] : r2[i][v3n_pkg::RootW-1:0];
      q_nxt.nb[i]  = {d_in.nb[i][v3n_pkg::QW-2:0], 1'b0};
      q_nxt.quo[i] = {d_in.quo[i][v3n_pkg::QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

@@ design/vector3_normalize_core.sv @@
// Vector normalise core: Q16.16 vector in, Q1.30 unit vector and length out.
// One vector is taken every cycle while in_stall is low and results leave in
// order, one per input: magnitude, squares and sum take three stages, the
// square root is a chain of 32 cells with one root bit each, the division is
// a chain of 31 cells yielding one quotient bit per lane each, and the output
// register adds one. The whole pipe holds only while a result waits at the
// output under stall. A zero vector gives zero outputs and sets zero_length.
module vector3_normalize_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  v3n_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output v3n_pkg::out_t  out_data
);

  localparam int unsigned W = v3n_pkg::CompW;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front stages
  logic                                  s0_valid_r, s1_valid_r, s2_valid_r;
  logic [v3n_pkg::Lanes-1:0][W-1:0]      s0_mag_r, s1_mag_r, s2_mag_r;
  logic [v3n_pkg::Lanes-1:0]             s0_neg_r, s1_neg_r, s2_neg_r;
  logic [v3n_pkg::Lanes-1:0][v3n_pkg::SqW-1:0] s1_sq_r;
  logic [v3n_pkg::SqW-1:0]               s2_sum_r;
  logic [v3n_pkg::Lanes-1:0][W-1:0]      raw;

  assign raw = {in_data.vec_z, in_data.vec_y, in_data.vec_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < v3n_pkg::Lanes; i++) begin
        s0_neg_r[i] <= raw[i][W-1];
        s0_mag_r[i] <= raw[i][W-1] ? (~raw[i] + W'(1)) : raw[i];
        s1_sq_r[i]  <= s0_mag_r[i] * s0_mag_r[i];
      end
      s1_mag_r <= s0_mag_r;
      s1_neg_r <= s0_neg_r;
      s2_sum_r <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
    end
  end

  // square root chain
  v3n_pkg::sq_t sq_w [v3n_pkg::RootW+1];

  always_comb begin
    sq_w[0].valid = s2_valid_r;
    sq_w[0].rad   = s2_sum_r;
    sq_w[0].rem   = '0;
    sq_w[0].root  = '0;
    sq_w[0].mag   = s2_mag_r;
    sq_w[0].neg   = s2_neg_r;
  end

  for (genvar g = 0; g < v3n_pkg::RootW; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (sq_w[g]),
      .d_out (sq_w[g+1])
    );
  end

  // division chain
  v3n_pkg::dv_t dv_w [v3n_pkg::QW+1];

  always_comb begin
    dv_w[0].valid = sq_w[v3n_pkg::RootW].valid;
    dv_w[0].len   = sq_w[v3n_pkg::RootW].root;
    dv_w[0].neg   = sq_w[v3n_pkg::RootW].neg;
    dv_w[0].quo   = '0;
    for (int i = 0; i < v3n_pkg::Lanes; i++) begin
      dv_w[0].rem[i] = {1'b0, sq_w[v3n_pkg::RootW].mag[i][W-1:1]};
      dv_w[0].nb[i]  = {sq_w[v3n_pkg::RootW].mag[i][0], {v3n_pkg::Q30Sh{1'b0}}};
    end
  end

  for (genvar g = 0; g < v3n_pkg::QW; g++) begin : g_div
    v3n_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dv_w[g]),
      .d_out (dv_w[g+1])
    );
  end

  // output register
  v3n_pkg::dv_t                     last;
  logic                             zero;
  logic [v3n_pkg::Lanes-1:0][W-1:0] unit;
  logic                             out_valid_r;
  v3n_pkg::out_t                    out_data_r, out_data_nxt;

  assign last = dv_w[v3n_pkg::QW];
  assign zero = (last.len == '0);

  always_comb begin
    for (int i = 0; i < v3n_pkg::Lanes; i++) begin
      if (zero) begin
        unit[i] = '0;
      end else if (last.neg[i]) begin
        unit[i] = ~{1'b0, last.quo[i]} + W'(1);
      end else begin
        unit[i] = {1'b0, last.quo[i]};
      end
    end
    out_data_nxt.unit_x      = unit[0];
    out_data_nxt.unit_y      = unit[1];
    out_data_nxt.unit_z      = unit[2];
    out_data_nxt.vec_length  = last.len;
    out_data_nxt.zero_length = zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/vector3_normalize_core_checker.sv @@
// Port-level checker for the vector normalise core, with its bind
`include "vector3_normalize_core_assert.svh"

module vector3_normalize_core_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input v3n_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input v3n_pkg::out_t out_data
);

  `V3N_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  `V3N_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `V3N_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)
  `V3N_ASSERT_NOW(a_zero_flag, out_valid && out_data.zero_length, out_data.vec_length == '0 && out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
  `V3N_ASSERT_NOW(a_len_flag, out_valid && out_data.vec_length == '0, out_data.zero_length)

endmodule

bind vector3_normalize_core vector3_normalize_core_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/v3n_checker.sv @@
// Checker: predicts unit vector and length per transfer in and compares results
`timescale 1ns / 100ps
module v3n_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  v3n_pkg::in_t   in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  v3n_pkg::out_t  out_data,
  output int             fail_count,
  output int             pending
);

  v3n_pkg::out_t expected_q[$];

  function automatic logic [31:0] mag32(logic [31:0] raw);
    return raw[31] ? (~raw + 32'd1) : raw;
  endfunction

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [31:0] unit_of(logic [31:0] raw, logic [31:0] len);
    logic [63:0] q;
    q = ({32'd0, mag32(raw)} << 30) / {32'd0, len};
    if (raw[31]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic v3n_pkg::out_t normalise(v3n_pkg::in_t v);
    v3n_pkg::out_t r;
    logic [63:0] mx, my, mz, sum;
    logic [31:0] len;
    mx = {32'd0, mag32(v.vec_x)};
    my = {32'd0, mag32(v.vec_y)};
    mz = {32'd0, mag32(v.vec_z)};
    sum = mx * mx + my * my + mz * mz;
    len = isqrt(sum);
    r = '0;
    if (len == 0) begin
      r.zero_length = 1'b1;
    end else begin
      r.unit_x = unit_of(v.vec_x, len);
      r.unit_y = unit_of(v.vec_y, len);
      r.unit_z = unit_of(v.vec_z, len);
      r.vec_length = len;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    v3n_pkg::out_t e;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(normalise(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.unit_x !== e.unit_x) begin
            $error("unit_x exp %h got %h", e.unit_x, out_data.unit_x); fail_count++;
          end
          if (out_data.unit_y !== e.unit_y) begin
            $error("unit_y exp %h got %h", e.unit_y, out_data.unit_y); fail_count++;
          end
          if (out_data.unit_z !== e.unit_z) begin
            $error("unit_z exp %h got %h", e.unit_z, out_data.unit_z); fail_count++;
          end
          if (out_data.vec_length !== e.vec_length) begin
            $error("vec_length exp %h got %h", e.vec_length, out_data.vec_length);
            fail_count++;
          end
          if (out_data.zero_length !== e.zero_length) begin
            $error("zero_length exp %b got %b", e.zero_length, out_data.zero_length);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/testbench.sv @@
// Testbench top: stimulus, idling phases and verdict for the vector normalise core
`timescale 1ns / 100ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  v3n_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  v3n_pkg::out_t out_data;
  int   fail_count, pending;
  int   send_idle_pct = 0, recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   idle_cycles = 0;

  v3n_pkg::in_t  vectors[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector3_normalize_core dut (.*);

  v3n_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(255) - 128;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      3: return 32'h8000_0000 | $urandom_range(3);
      4: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return 32'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  function automatic v3n_pkg::in_t make_vec(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
    v3n_pkg::in_t v;
    v.vec_x = x; v.vec_y = y; v.vec_z = z;
    return v;
  endfunction

  task automatic send_all();
    v3n_pkg::in_t v;
    while (vectors.size() > 0) begin
      v = vectors.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= v;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    vectors.push_back(make_vec(0, 0, 0));
    vectors.push_back(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    vectors.push_back(make_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    vectors.push_back(make_vec(32'h8000_0000, 0, 0));
    vectors.push_back(make_vec(0, 32'h7FFF_FFFF, 0));
    vectors.push_back(make_vec(0, 0, 32'hFFFF_FFFF));
    vectors.push_back(make_vec(1, 0, 0));
    vectors.push_back(make_vec(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
    vectors.push_back(make_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    vectors.push_back(make_vec(32'h0003_0000, 32'hFFFC_0000, 0));
    vectors.push_back(make_vec(32'h8000_0000, 32'h7FFF_FFFF, 1));
    vectors.push_back(make_vec(0, 0, 32'h8000_0000));
    vectors.push_back(make_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
    send_all();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 360; i++)
        vectors.push_back(make_vec(rand_comp(), rand_comp(), rand_comp()));
      if (ph == 4) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
          send_all();
        join
      end else begin
        send_all();
      end
    end

    fork
      drain();
      begin
        repeat (20000) @(posedge clk);
        $display("testbench: errors");
        $finish;
      end
    join_any
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
